/* hdl/sha256h_pkg.sv */
// ============================================================================
// sha256h_pkg
// Shared types, initial hash words and round constants for the SHA-256 core.
// ============================================================================
package sha256h_pkg;

    typedef logic [31:0] word_t;

    // Index 0 holds H0 (or working variable a), index 7 holds H7 (or h).
    typedef word_t [7:0] hash_t;

    // Controls for the message schedule window.
    typedef struct packed {
        logic  load;     // shift a message or padding word into the window
        logic  advance;  // shift in the next expanded schedule word
        word_t word;     // word that goes with load
    } sched_ctrl_t;

    function automatic hash_t iv_hash();
        hash_t h;
        h[0] = 32'h6a09e667;
        h[1] = 32'hbb67ae85;
        h[2] = 32'h3c6ef372;
        h[3] = 32'ha54ff53a;
        h[4] = 32'h510e527f;
        h[5] = 32'h9b05688c;
        h[6] = 32'h1f83d9ab;
        h[7] = 32'h5be0cd19;
        return h;
    endfunction

    function automatic word_t round_k(input logic [5:0] r);
        word_t k;
        unique case (r)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic word_t ror(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

/* hdl/sha256h_sched.sv */
// ============================================================================
// sha256h_sched
// Sixteen-word block buffer that doubles as the message schedule window.
// ============================================================================
module sha256h_sched
    import sha256h_pkg::*;
(
    input  logic        clk,
    input  sched_ctrl_t ctrl,
    output word_t       w
);

    // Entry 0 is the oldest word; it is the schedule word of the current round.
    word_t [15:0] window_reg;
    word_t        window_next;
    word_t        expand_word;
    word_t        sig0;
    word_t        sig1;

    always_comb
    begin
        sig0 = ror(window_reg[1], 7) ^ ror(window_reg[1], 18) ^ (window_reg[1] >> 3);
        sig1 = ror(window_reg[14], 17) ^ ror(window_reg[14], 19) ^ (window_reg[14] >> 10);
        expand_word = window_reg[0] + sig0 + window_reg[9] + sig1;
        window_next = ctrl.load ? ctrl.word : expand_word;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load || ctrl.advance)
        begin
            window_reg <= {window_next, window_reg[15:1]};
        end
    end

    assign w = window_reg[0];

endmodule

/* hdl/sha256h_round.sv */
// ============================================================================
// sha256h_round
// One SHA-256 compression round, shared by all 64 rounds of a block.
// ============================================================================
module sha256h_round
    import sha256h_pkg::*;
(
    input  hash_t vars,
    input  word_t w,
    input  word_t k,
    output hash_t vars_next
);

    word_t s1;
    word_t ch;
    word_t t1;
    word_t s0;
    word_t mj;
    word_t t2;

    always_comb
    begin
        s1 = ror(vars[4], 6) ^ ror(vars[4], 11) ^ ror(vars[4], 25);
        ch = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
        t1 = vars[7] + s1 + ch + k + w;
        s0 = ror(vars[0], 2) ^ ror(vars[0], 13) ^ ror(vars[0], 22);
        mj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
        t2 = s0 + mj;

        vars_next[7] = vars[6];
        vars_next[6] = vars[5];
        vars_next[5] = vars[4];
        vars_next[4] = vars[3] + t1;
        vars_next[3] = vars[2];
        vars_next[2] = vars[1];
        vars_next[1] = vars[0];
        vars_next[0] = t1 + t2;
    end

endmodule

/* hdl/sha256_hasher_core.sv */
// ============================================================================
// sha256_hasher_core
// Flow: words are taken only in IDLE; the sixteenth word of a block starts
//   the rounds, run by the single shared round unit at one round per cycle.
// Finish: after the final word come the padding words and the rounds of the
//   last one or two blocks, then eight digest transfers, one per cycle when
//   not stalled.
// Reset: rst_n clears the sequencer and loads the initial hash words at once.
// ============================================================================
module sha256_hasher_core
    import sha256h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        end_of_message,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    // The sequencer takes message words in IDLE. The final word moves it
    // through the padding states, which push one word per cycle into the
    // block buffer. Any push that completes a block detours through ROUNDS
    // and then comes back to the state saved in resume_reg.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUNDS,
        ST_MARK,
        ST_ZERO,
        ST_LEN_LO,
        ST_EMIT
    } state_t;

    state_t       state_reg;
    state_t       resume_reg;
    state_t       after_push;
    logic [3:0]   fill_reg;
    logic [5:0]   round_reg;
    logic [2:0]   out_idx_reg;
    logic [60:0]  byte_total_reg;
    hash_t        cv_reg;
    hash_t        vars_reg;
    hash_t        vars_next;
    hash_t        cv_sum;

    logic         push;
    word_t        push_word;
    logic [2:0]   byte_add;
    word_t        final_word;
    logic [2:0]   final_bytes;
    logic         final_full;
    word_t        len_hi;
    word_t        len_lo;
    word_t        sched_w;
    sched_ctrl_t  sched_ctrl;

    // The 64-bit bit length is the byte count shifted left by three.
    assign len_hi = byte_total_reg[60:29];
    assign len_lo = {byte_total_reg[28:0], 3'b000};

    // Final word: keep the valid leading bytes, clear the rest and place the
    // 0x80 marker right after them. A count above four counts as four, and
    // then the marker goes into a word of its own.
    always_comb
    begin
        unique case (valid_bytes)
            3'd0:
            begin
                final_word  = 32'h8000_0000;
                final_bytes = 3'd0;
                final_full  = 1'b0;
            end
            3'd1:
            begin
                final_word  = {data_word[31:24], 24'h80_0000};
                final_bytes = 3'd1;
                final_full  = 1'b0;
            end
            3'd2:
            begin
                final_word  = {data_word[31:16], 16'h8000};
                final_bytes = 3'd2;
                final_full  = 1'b0;
            end
            3'd3:
            begin
                final_word  = {data_word[31:8], 8'h80};
                final_bytes = 3'd3;
                final_full  = 1'b0;
            end
            default:
            begin
                final_word  = data_word;
                final_bytes = 3'd4;
                final_full  = 1'b1;
            end
        endcase
    end

    // Select the word pushed into the block buffer this cycle and the state
    // that follows the push when it does not complete a block.
    always_comb
    begin
        push       = 1'b0;
        push_word  = '0;
        byte_add   = 3'd4;
        after_push = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                push = in_valid;
                if (end_of_message)
                begin
                    push_word  = final_word;
                    byte_add   = final_bytes;
                    after_push = final_full ? ST_MARK : ST_ZERO;
                end
                else
                begin
                    push_word  = data_word;
                    after_push = ST_IDLE;
                end
            end
            ST_MARK:
            begin
                push       = 1'b1;
                push_word  = 32'h8000_0000;
                after_push = ST_ZERO;
            end
            ST_ZERO:
            begin
                // Zero fill runs until two slots are left for the length.
                push = 1'b1;
                if (fill_reg == 4'd14)
                begin
                    push_word  = len_hi;
                    after_push = ST_LEN_LO;
                end
                else
                begin
                    push_word  = '0;
                    after_push = ST_ZERO;
                end
            end
            ST_LEN_LO:
            begin
                // This push always fills the last slot, so rounds follow.
                push       = 1'b1;
                push_word  = len_lo;
                after_push = ST_EMIT;
            end
            ST_ROUNDS, ST_EMIT:
            begin
                push = 1'b0;
            end
        endcase
    end

    assign sched_ctrl.load    = push;
    assign sched_ctrl.advance = (state_reg == ST_ROUNDS);
    assign sched_ctrl.word    = push_word;

    sha256h_sched u_sched (
        .clk  (clk),
        .ctrl (sched_ctrl),
        .w    (sched_w)
    );

    sha256h_round u_round (
        .vars      (vars_reg),
        .w         (sched_w),
        .k         (round_k(round_reg)),
        .vars_next (vars_next)
    );

    // Chaining value update after the last round of a block.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            cv_sum[i] = cv_reg[i] + vars_next[i];
        end
    end

    // Sequencer, chaining value, counters and the output index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            resume_reg     <= ST_IDLE;
            fill_reg       <= '0;
            round_reg      <= '0;
            out_idx_reg    <= '0;
            byte_total_reg <= '0;
            cv_reg         <= iv_hash();
        end
        else
        begin
            if (push)
            begin
                fill_reg <= fill_reg + 4'd1;
                if (state_reg == ST_IDLE)
                begin
                    byte_total_reg <= byte_total_reg + {58'd0, byte_add};
                end
                if (fill_reg == 4'd15)
                begin
                    state_reg  <= ST_ROUNDS;
                    resume_reg <= after_push;
                    round_reg  <= '0;
                end
                else
                begin
                    state_reg <= after_push;
                end
            end
            else if (state_reg == ST_ROUNDS)
            begin
                round_reg <= round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    cv_reg    <= cv_sum;
                    state_reg <= resume_reg;
                end
            end
            else if (state_reg == ST_EMIT && !out_stall)
            begin
                out_idx_reg <= out_idx_reg + 3'd1;
                if (out_idx_reg == 3'd7)
                begin
                    // Last digest transfer: start over for the next message.
                    cv_reg         <= iv_hash();
                    byte_total_reg <= '0;
                    fill_reg       <= '0;
                    state_reg      <= ST_IDLE;
                end
            end
        end
    end

    // Working variables load from the chaining value when a block completes
    // and then step once per round.
    always_ff @(posedge clk)
    begin
        if (push && fill_reg == 4'd15)
        begin
            vars_reg <= cv_reg;
        end
        else if (state_reg == ST_ROUNDS)
        begin
            vars_reg <= vars_next;
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = (state_reg == ST_EMIT);
    assign digest_word = cv_reg[out_idx_reg];
    assign word_index  = out_idx_reg;
    assign last_word   = (out_idx_reg == 3'd7);

endmodule

/* sim/tb.sv */
// ============================================================================
// tb: self-checking bench for sha256_hasher_core
// Streams whole messages into the hasher as 32-bit words and compares each
// digest word transfer against a bit-accurate SHA-256 predictor kept in the
// bench. A short directed table covers the empty message, a known digest,
// odd byte counts and two-block padding. Random messages follow, with random
// idle gaps on the input and random stalls on the output.
// ============================================================================
module tb;

    // Clock, reset and DUT ports. Every input starts at a known value.
    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic [31:0] data_word      = '0;
    logic [2:0]  valid_bytes    = '0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_stall      = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    localparam int RANDOM_WORDS = 386;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 200;

    // Well-known digests, word 0 in the top bits.
    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

    // Initial hash words, H0 in the top bits.
    localparam logic [255:0] START_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    // Round constants, round 0 in the top bits.
    localparam logic [64*32-1:0] ROUND_CONST = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    // One row of the directed table. When has_digest is set, the digest that
    // the message ends with is typed in and used instead of the predictor's.
    typedef struct packed {
        logic [31:0]  data;
        logic [2:0]   nbytes;
        logic         eom;
        logic         has_digest;
        logic [255:0] digest;
    } msg_word_t;

    // One expected digest word transfer.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    msg_word_t    directed_words[$];
    digest_word_t pending_digest[$];

    // Predictor state: chaining value, block being filled, fill level and
    // the running byte count that ends up in the length field.
    logic [31:0] hash_state [0:7];
    logic [31:0] msg_block  [0:15];
    int unsigned block_fill;
    logic [60:0] msg_bytes;

    int unsigned cycle_count   = 0;
    int unsigned mismatches    = 0;
    int unsigned words_taken   = 0;
    int unsigned stall_left    = 0;
    int unsigned free_left     = 0;
    bit          pressure_done = 1'b0;

    sha256_hasher_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_word      (data_word),
        .valid_bytes    (valid_bytes),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // SHA-256 predictor
    // ------------------------------------------------------------------

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        logic [63:0] twice;
        twice = {x, x} >> n;
        return twice[31:0];
    endfunction

    // Restores the state that the block has after reset and after a digest.
    task automatic restart_hash();
        int i;
        for (i = 0; i < 8; i++)
        begin
            hash_state[i] = START_HASH[255 - 32 * i -: 32];
        end
        block_fill = 0;
        msg_bytes  = '0;
    endtask

    // Runs the 64 rounds over the full block and folds the result into the
    // chaining value.
    task automatic compress_block();
        logic [31:0] sched [0:63];
        logic [31:0] v [0:7];
        logic [31:0] sig0, sig1, t1, t2, choose, major;
        int i;
        for (i = 0; i < 16; i++)
        begin
            sched[i] = msg_block[i];
        end
        for (i = 16; i < 64; i++)
        begin
            sig0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
            sig1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
            sched[i] = sched[i-16] + sig0 + sched[i-7] + sig1;
        end
        for (i = 0; i < 8; i++)
        begin
            v[i] = hash_state[i];
        end
        for (i = 0; i < 64; i++)
        begin
            sig1   = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
            choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1     = v[7] + sig1 + choose + ROUND_CONST[2047 - 32 * i -: 32] + sched[i];
            sig0   = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
            major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2     = sig0 + major;
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (i = 0; i < 8; i++)
        begin
            hash_state[i] = hash_state[i] + v[i];
        end
    endtask

    task automatic append_block_word(input logic [31:0] w);
        msg_block[block_fill] = w;
        if (block_fill == 15)
        begin
            compress_block();
            block_fill = 0;
        end
        else
        begin
            block_fill++;
        end
    endtask

    // Absorbs one accepted word. On the final word it pads, finishes the
    // hash, hands back the digest, and restarts for the next message.
    task automatic absorb_word(input logic [31:0] data, input logic [2:0] nbytes,
                               input logic eom, output bit finished,
                               output logic [255:0] digest);
        int unsigned count;
        logic [31:0] keep;
        logic [63:0] bit_len;
        int i;
        finished = 1'b0;
        digest   = '0;
        if (!eom)
        begin
            append_block_word(data);
            msg_bytes = msg_bytes + 61'd4;
        end
        else
        begin
            // Counts of five to seven act as a full word.
            count = (nbytes > 3'd4) ? 4 : nbytes;
            msg_bytes = msg_bytes + 61'(count);
            if (count == 4)
            begin
                append_block_word(data);
                append_block_word(32'h80000000);
            end
            else
            begin
                // Bytes past the count are cleared before the pad byte goes in.
                keep = 32'hFFFFFFFF << (8 * (4 - count));
                append_block_word((data & keep) | (32'h80 << (8 * (3 - count))));
            end
            // No room left for the length: pad out a whole extra block.
            if (block_fill == 15)
            begin
                append_block_word(32'h0);
            end
            while (block_fill != 14)
            begin
                append_block_word(32'h0);
            end
            bit_len = {msg_bytes, 3'b000};
            append_block_word(bit_len[63:32]);
            append_block_word(bit_len[31:0]);
            for (i = 0; i < 8; i++)
            begin
                digest[255 - 32 * i -: 32] = hash_state[i];
            end
            finished = 1'b1;
            restart_hash();
        end
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Idles for the given cycles, then offers one word and holds it until the
    // transfer happens. The predictor runs once in_stall is low after an edge.
    task automatic send_word(input msg_word_t item, input int unsigned idle);
        bit          finished;
        logic [255:0] digest;
        int i;
        if (idle > 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid       <= 1'b1;
        data_word      <= item.data;
        valid_bytes    <= item.nbytes;
        end_of_message <= item.eom;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        absorb_word(item.data, item.nbytes, item.eom, finished, digest);
        if (finished)
        begin
            if (item.has_digest)
            begin
                digest = item.digest;
            end
            for (i = 0; i < 8; i++)
            begin
                pending_digest.push_back('{digest[255 - 32 * i -: 32], 3'(i), i == 7});
            end
        end
    endtask

    // Input-side idle choice: a calm message sends back to back.
    function automatic int unsigned input_gap(input bit calm);
        if (calm || $urandom_range(0, 99) < 60)
        begin
            return 0;
        end
        return pick_gap();
    endfunction

    initial
    begin
        msg_word_t   item;
        int unsigned msg_len;
        int unsigned r;
        int unsigned sent;
        bit          calm;
        int i;

        restart_hash();

        // Directed table. The empty message and "abc" carry their published
        // digests; the rest is left to the predictor.
        // Empty message, then the same with junk in the unused bytes.
        directed_words.push_back('{32'h00000000, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST});
        directed_words.push_back('{32'hFFFFFFFF, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST});
        // "abc" with a nonzero byte past the count.
        directed_words.push_back('{32'h616263A5, 3'd3, 1'b1, 1'b1, ABC_DIGEST});
        // Counts above four act as four.
        directed_words.push_back('{32'hFFFFFFFF, 3'd7, 1'b1, 1'b0, 256'h0});
        directed_words.push_back('{32'h00000000, 3'd5, 1'b1, 1'b0, 256'h0});
        // Zero count on a non-empty message; the count on the first word is
        // ignored since it is not final.
        directed_words.push_back('{32'h12345678, 3'd6, 1'b0, 1'b0, 256'h0});
        directed_words.push_back('{32'hDEADBEEF, 3'd0, 1'b1, 1'b0, 256'h0});
        // Single-byte and two-byte messages.
        directed_words.push_back('{32'h89ABCDEF, 3'd1, 1'b1, 1'b0, 256'h0});
        directed_words.push_back('{32'h0F0F0F0F, 3'd2, 1'b1, 1'b0, 256'h0});
        // Fifteen words leave no room for the length, so padding takes a
        // second block.
        for (i = 0; i < 14; i++)
        begin
            directed_words.push_back('{(i % 2) ? 32'h00000000 : 32'hFFFFFFFF,
                                       3'(i), 1'b0, 1'b0, 256'h0});
        end
        directed_words.push_back('{32'hC0FFEE11, 3'd2, 1'b1, 1'b0, 256'h0});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_words[k])
        begin
            send_word(directed_words[k], input_gap(1'b0));
        end

        // Random messages: mostly short, some spanning several blocks. The
        // final count is drawn over all eight codes, so zero counts on
        // non-empty messages and oversized counts keep showing up.
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                msg_len = $urandom_range(0, 17);
            end
            else if (r < 92)
            begin
                msg_len = $urandom_range(18, 48);
            end
            else
            begin
                msg_len = $urandom_range(49, 70);
            end
            calm = ($urandom_range(0, 3) == 0);
            for (i = 0; i <= msg_len; i++)
            begin
                item.data       = $urandom();
                item.nbytes     = 3'($urandom_range(0, 7));
                item.eom        = (i == msg_len);
                item.has_digest = 1'b0;
                item.digest     = '0;
                send_word(item, input_gap(calm));
                sent++;
            end
        end
        in_valid <= 1'b0;

        while (pending_digest.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("sha256_hasher_core verification clean");
        end
        else
        begin
            $display("sha256_hasher_core verification failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side: check each digest transfer and choose the next stall.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        digest_word_t want;

        if (out_valid && !out_stall)
        begin
            words_taken++;
            if (pending_digest.size() == 0)
            begin
                $error("digest transfer with nothing expected: word %h index %0d",
                       digest_word, word_index);
                mismatches++;
            end
            else
            begin
                want = pending_digest.pop_front();
                if (digest_word !== want.word)
                begin
                    $error("digest_word: expected %h, got %h", want.word, digest_word);
                    mismatches++;
                end
                if (word_index !== want.index)
                begin
                    $error("word_index: expected %0d, got %0d", want.index, word_index);
                    mismatches++;
                end
                if (last_word !== want.last)
                begin
                    $error("last_word: expected %0b, got %0b", want.last, last_word);
                    mismatches++;
                end
            end
        end

        // Once, early in the random messages, the output holds off for a
        // long stretch while the input keeps offering words. The core cannot
        // drain its digest, so it has to push back on the input.
        if (!pressure_done && words_taken >= 80)
        begin
            pressure_done = 1'b1;
            stall_left    = HOLD_CYCLES;
            free_left     = 0;
        end

        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (free_left > 0)
            begin
                free_left--;
            end
            else if ($urandom_range(0, 99) < 8)
            begin
                // A stretch with no stalls at all.
                free_left = $urandom_range(20, 80);
            end
            else if ($urandom_range(0, 99) < 35)
            begin
                // The stall starts on the next edge; this cycle is free.
                stall_left = pick_gap();
            end
        end
    end

    // Guard against a hung core.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sha256_hasher_core verification failed");
            $finish;
        end
    end

endmodule

/* sha256_hasher_core.f */
hdl/sha256h_pkg.sv
hdl/sha256h_sched.sv
hdl/sha256h_round.sv
hdl/sha256_hasher_core.sv
sim/tb.sv
